// File: hdl/shot_vibration_detector_core_macros.svh
// Assertion shorthands for the shot detector; clk and rst_n must be in scope.
`ifndef SHOT_VIBRATION_DETECTOR_CORE_MACROS_SVH
`define SHOT_VIBRATION_DETECTOR_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/svd_pkg.sv
package svd_pkg;

  localparam int THR_W      = 15;
  localparam int MS_W       = 16;
  localparam int HITS_W     = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Gravity in 1/128 m/s^2 units
  localparam int GRAV_W = 11;
  localparam logic [GRAV_W-1:0] GRAVITY_Q7 = 11'd1256;

  // (G+T) fits 16 bits for any 15-bit T, (G-T) fits 11 bits when positive
  localparam int HI_W    = 16;
  localparam int HI_SQ_W = 32;
  localparam int LO_SQ_W = 22;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 15'd256;
  localparam logic [MS_W-1:0]   WINDOW_RST    = 16'd2000;
  localparam logic [MS_W-1:0]   COOLDOWN_RST  = 16'd3000;
  localparam logic [HITS_W-1:0] HITS_REQ_RST  = 8'd3;

  localparam logic [HI_SQ_W-1:0] HI_SQ_RST = 32'd2286144;  // 1512 squared
  localparam logic [LO_SQ_W-1:0] LO_SQ_RST = 22'd1000000;  // 1000 squared

  localparam logic [MS_W-1:0]   MS_MAX   = 16'hFFFF;
  localparam logic [HITS_W-1:0] HITS_MAX = 8'hFF;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_COOLDOWN  = 2'd2;
  localparam logic [1:0] REG_HITS_REQ  = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_DETECTING = 2'd1,
    MODE_DETECTED  = 2'd2
  } mode_t;

endpackage

// File: hdl/svd_channels.sv
interface svd_in_if #(
  parameter int ACCEL_WIDTH = 16
);
  import svd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [KIND_W-1:0]             kind;
  logic signed [ACCEL_WIDTH-1:0] accel_x;
  logic signed [ACCEL_WIDTH-1:0] accel_y;
  logic signed [ACCEL_WIDTH-1:0] accel_z;
  logic                          sample_valid;

  modport source (
    output valid, kind, accel_x, accel_y, accel_z, sample_valid,
    input  ready
  );
  modport sink (
    input  valid, kind, accel_x, accel_y, accel_z, sample_valid,
    output ready
  );
endinterface

interface svd_out_if;
  import svd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        detector_state;
  logic              shot_flag;
  logic [HITS_W-1:0] hit_count;

  modport source (
    output valid, detector_state, shot_flag, hit_count,
    input  ready
  );
  modport sink (
    input  valid, detector_state, shot_flag, hit_count,
    output ready
  );
endinterface

// File: hdl/shot_vibration_detector_core.sv
// Armed shot detector on three-axis accelerometer words. Each input word (tick, sample or
// arm) yields exactly one result word carrying the detector state, a shot flag that is set
// only on the word that enters detected, and the saturating hit count. One word per cycle is
// taken sustained while results are read: an accepted word waits in the input register
// while its squares, the band compare and the state update are worked out; the result
// register loads once it is free or its result is being taken. While a result waits
// unread, the input register holds one more word and input ready then drops until the result
// is taken. The squared band limits are registered from the threshold register, so a
// threshold write reaches them through thr_r and then the hi_sq_r and lo_sq_r registers.
`include "shot_vibration_detector_core_macros.svh"

module shot_vibration_detector_core #(
  parameter int ACCEL_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  svd_in_if.sink                             in_ch,
  svd_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [svd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [svd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [svd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import svd_pkg::*;

  localparam int W      = ACCEL_WIDTH;
  localparam int SUM_W  = 2 * W;
  localparam int CMP_W  = (SUM_W > HI_SQ_W) ? SUM_W : HI_SQ_W;

  // ---------------- configuration ----------------
  logic [THR_W-1:0]   thr_r;
  logic [MS_W-1:0]    window_r;
  logic [MS_W-1:0]    cooldown_r;
  logic [HITS_W-1:0]  hits_req_r;
  logic [HI_SQ_W-1:0] hi_sq_r;
  logic [LO_SQ_W-1:0] lo_sq_r;
  logic               cfg_wr;
  logic [HI_W-1:0]    hi_sum;
  logic [GRAV_W-1:0]  lo_diff;
  logic               lo_en;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THRESHOLD_RST;
      window_r   <= WINDOW_RST;
      cooldown_r <= COOLDOWN_RST;
      hits_req_r <= HITS_REQ_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THRESHOLD: thr_r      <= pwdata[THR_W-1:0];
        REG_WINDOW:    window_r   <= pwdata[MS_W-1:0];
        REG_COOLDOWN:  cooldown_r <= pwdata[MS_W-1:0];
        REG_HITS_REQ:  hits_req_r <= pwdata[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = CFG_DATA_W'(thr_r);
      REG_WINDOW:    prdata = CFG_DATA_W'(window_r);
      REG_COOLDOWN:  prdata = CFG_DATA_W'(cooldown_r);
      REG_HITS_REQ:  prdata = CFG_DATA_W'(hits_req_r);
      default:       prdata = '0;
    endcase
  end

  // Band limits (G+T)^2 and (G-T)^2, lower limit only when G > T
  assign lo_en   = HI_W'(thr_r) < HI_W'(GRAVITY_Q7);
  assign hi_sum  = HI_W'(GRAVITY_Q7) + HI_W'(thr_r);
  assign lo_diff = GRAVITY_Q7 - thr_r[GRAV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_sq_r <= HI_SQ_RST;
      lo_sq_r <= LO_SQ_RST;
    end else begin
      hi_sq_r <= HI_SQ_W'(hi_sum) * HI_SQ_W'(hi_sum);
      lo_sq_r <= LO_SQ_W'(lo_diff) * LO_SQ_W'(lo_diff);
    end
  end

  // ---------------- handshake ----------------
  logic s1_v_r, out_v_r;
  logic out_can, s1_can, s1_fire;

  assign out_can     = !out_v_r || out_ch.ready;
  assign s1_can      = !s1_v_r || out_can;
  assign s1_fire     = s1_v_r && out_can;
  assign in_ch.ready = s1_can;

  // ---------------- input register ----------------
  logic [KIND_W-1:0]   s1_kind_r;
  logic signed [W-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic                s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_can) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_can) begin
      s1_kind_r  <= in_ch.kind;
      s1_ax_r    <= in_ch.accel_x;
      s1_ay_r    <= in_ch.accel_y;
      s1_az_r    <= in_ch.accel_z;
      s1_valid_r <= in_ch.sample_valid;
    end
  end

  // ---------------- hit test ----------------
  logic [W-1:0]     mag_x, mag_y, mag_z;
  logic [SUM_W-1:0] prod_x, prod_y, prod_z;
  logic [SUM_W-1:0] mag_sq;
  logic [CMP_W-1:0] mag_cmp;
  logic             s1_quiet, over_band, under_band, s1_hit;

  assign mag_x = s1_ax_r[W-1] ? (~s1_ax_r + W'(1)) : s1_ax_r;
  assign mag_y = s1_ay_r[W-1] ? (~s1_ay_r + W'(1)) : s1_ay_r;
  assign mag_z = s1_az_r[W-1] ? (~s1_az_r + W'(1)) : s1_az_r;

  assign prod_x = SUM_W'(mag_x) * SUM_W'(mag_x);
  assign prod_y = SUM_W'(mag_y) * SUM_W'(mag_y);
  assign prod_z = SUM_W'(mag_z) * SUM_W'(mag_z);
  // near zero on every axis: |a| <= 1
  assign s1_quiet = (mag_x[W-1:1] == '0) && (mag_y[W-1:1] == '0)
                 && (mag_z[W-1:1] == '0);

  assign mag_sq     = prod_x + prod_y + prod_z;
  assign mag_cmp    = CMP_W'(mag_sq);
  assign over_band  = mag_cmp > CMP_W'(hi_sq_r);
  assign under_band = lo_en && (mag_cmp < CMP_W'(lo_sq_r));
  assign s1_hit     = s1_valid_r && !s1_quiet && (over_band || under_band);

  // ---------------- detector state ----------------
  mode_t             mode_r, mode_a, mode_b, mode_nxt;
  logic [HITS_W-1:0] hits_r, hits_nxt, hits_base, hits_inc;
  logic [MS_W-1:0]   elapsed_r, elapsed_nxt, elapsed_tick;
  logic              win_out, score, shot, arm;

  // datapath: timers, hit count, pulse
  always_comb begin
    elapsed_tick = elapsed_r;
    if (s1_kind_r == KIND_TICK && elapsed_r != MS_MAX) begin
      elapsed_tick = elapsed_r + MS_W'(1);
    end
    win_out   = (mode_r == MODE_DETECTING) && (elapsed_tick > window_r);
    mode_a    = win_out ? MODE_IDLE : mode_r;
    hits_base = win_out ? '0 : hits_r;
    score     = (s1_kind_r == KIND_SAMPLE) && (mode_a == MODE_DETECTING) && s1_hit;
    hits_inc  = (score && hits_base != HITS_MAX) ? hits_base + HITS_W'(1) : hits_base;
    shot      = score && (hits_inc >= hits_req_r);
    arm       = (s1_kind_r == KIND_ARM) && (mode_a != MODE_DETECTING);
    hits_nxt    = arm ? '0 : hits_inc;
    elapsed_nxt = arm ? '0 : elapsed_tick;
  end

  // next state
  always_comb begin
    mode_b = mode_a;
    if (shot) begin
      mode_b = MODE_DETECTED;
    end else if (arm) begin
      mode_b = MODE_DETECTING;
    end
    mode_nxt = mode_b;
    if (mode_b == MODE_DETECTED && elapsed_nxt > cooldown_r) begin
      mode_nxt = MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hits_r    <= '0;
      elapsed_r <= '0;
    end else if (s1_fire) begin
      mode_r    <= mode_nxt;
      hits_r    <= hits_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [1:0]        out_state_r;
  logic              out_shot_r;
  logic [HITS_W-1:0] out_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_can) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_state_r <= mode_nxt;
      out_shot_r  <= shot;
      out_hits_r  <= hits_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.detector_state = out_state_r;
  assign out_ch.shot_flag      = out_shot_r;
  assign out_ch.hit_count      = out_hits_r;

  // ---------------- checks ----------------
  `SVD_ASSERT_NEXT(a_shot_lands, s1_fire && shot, mode_r != MODE_DETECTING, "bad shot state")
  `SVD_ASSERT_NEXT(a_arm_lands, s1_fire && arm, mode_r == MODE_DETECTING, "arm not applied")
  `SVD_ASSERT_NEXT(a_out_hold, out_v_r && !out_ch.ready, out_v_r, "result dropped")
  `SVD_ASSERT_NOW(a_in_block, s1_v_r && !out_can, !in_ch.ready, "input taken while full")

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import svd_pkg::*;

  localparam int AW          = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    mode_t             mode;
    logic              pulse;
    logic [HITS_W-1:0] hits;
  } det_result_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  svd_in_if #(.ACCEL_WIDTH(AW)) in_if ();
  svd_out_if out_if ();

  shot_vibration_detector_core #(.ACCEL_WIDTH(AW)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Detector copy: registers and state
  logic [THR_W-1:0]  thr_cfg;
  logic [MS_W-1:0]   window_cfg;
  logic [MS_W-1:0]   cooldown_cfg;
  logic [HITS_W-1:0] need_cfg;
  mode_t             det_mode;
  logic [HITS_W-1:0] hit_tally;
  logic [MS_W-1:0]   elapsed;

  det_result_t expected_results[$];

  int mismatches     = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int shots_seen     = 0;
  int settings_used  = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int hold_left      = 0;
  bit steady         = 1'b0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 20) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic bit is_shot_hit(input logic signed [AW-1:0] x, y, z);
    longint ax;
    longint ay;
    longint az;
    longint m;
    longint hi;
    longint lo;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    az = (z < 0) ? -longint'(z) : longint'(z);
    if (ax <= 1 && ay <= 1 && az <= 1) return 1'b0;
    m  = ax * ax + ay * ay + az * az;
    hi = longint'(GRAVITY_Q7) + longint'(thr_cfg);
    if (m > hi * hi) return 1'b1;
    if (longint'(GRAVITY_Q7) > longint'(thr_cfg)) begin
      lo = longint'(GRAVITY_Q7) - longint'(thr_cfg);
      if (m < lo * lo) return 1'b1;
    end
    return 1'b0;
  endfunction

  // One word through the detector: tick, timeouts, sample or arm, cooldown
  function automatic det_result_t advance_detector(input logic [KIND_W-1:0] kind,
                                                   input logic signed [AW-1:0] x, y, z,
                                                   input logic sv);
    det_result_t r;
    logic pulse;
    pulse = 1'b0;
    if (kind == KIND_TICK && elapsed != MS_MAX) elapsed++;
    if (det_mode == MODE_DETECTING && elapsed > window_cfg) begin
      det_mode  = MODE_IDLE;
      hit_tally = '0;
    end
    if (kind == KIND_SAMPLE) begin
      if (det_mode == MODE_DETECTING && sv && is_shot_hit(x, y, z)) begin
        if (hit_tally != HITS_MAX) hit_tally++;
        if (hit_tally >= need_cfg) begin
          det_mode = MODE_DETECTED;
          pulse    = 1'b1;
        end
      end
    end else if (kind == KIND_ARM) begin
      if (det_mode != MODE_DETECTING) begin
        det_mode  = MODE_DETECTING;
        elapsed   = '0;
        hit_tally = '0;
      end
    end
    if (det_mode == MODE_DETECTED && elapsed > cooldown_cfg) det_mode = MODE_IDLE;
    r.mode  = det_mode;
    r.pulse = pulse;
    r.hits  = hit_tally;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    det_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.shot_flag === 1'b1) shots_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_if.detector_state !== want.mode)
          report_mismatch($sformatf("detector_state %0d, want %0d",
                                    out_if.detector_state, want.mode));
        if (out_if.shot_flag !== want.pulse)
          report_mismatch($sformatf("shot_flag %0b, want %0b",
                                    out_if.shot_flag, want.pulse));
        if (out_if.hit_count !== want.hits)
          report_mismatch($sformatf("hit_count %0d, want %0d",
                                    out_if.hit_count, want.hits));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stall on a random ready mask, or hold off on request
  initial begin
    int pos;
    logic [7:0] mask;
    out_if.ready = 1'b0;
    mask = 8'hFF;
    pos  = 0;
    forever begin
      @(negedge clk);
      if (pos % 64 == 0) mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      pos++;
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= mask[pos % 8];
      end
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic signed [AW-1:0] x, y, z,
                           input logic sv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.accel_x      <= x;
    in_if.accel_y      <= y;
    in_if.accel_z      <= z;
    in_if.sample_valid <= sv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_results.push_back(advance_detector(kind, x, y, z, sv));
    words_sent++;
  endtask

  task automatic tick();
    send_word(KIND_TICK, AW'($urandom), AW'($urandom), AW'($urandom), 1'($urandom));
  endtask

  task automatic arm();
    send_word(KIND_ARM, AW'($urandom), AW'($urandom), AW'($urandom), 1'($urandom));
  endtask

  task automatic sample(input int x, y, z);
    send_word(KIND_SAMPLE, AW'(x), AW'(y), AW'(z), 1'b1);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] mask;
    case (idx)
      REG_THRESHOLD: mask = 32'h7FFF;
      REG_HITS_REQ:  mask = 32'hFF;
      default:       mask = 32'hFFFF;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    case (idx)
      REG_THRESHOLD: thr_cfg      = value[THR_W-1:0];
      REG_WINDOW:    window_cfg   = value[MS_W-1:0];
      REG_COOLDOWN:  cooldown_cfg = value[MS_W-1:0];
      default:       need_cfg     = value[HITS_W-1:0];
    endcase
    // read back from the same address
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== (value & mask))
      report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, value & mask));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int thr, win, cool, need);
    wait_results_done();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WINDOW, win);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_HITS_REQ, need);
    settings_used++;
  endtask

  function automatic logic signed [AW-1:0] clamp_accel(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return AW'(v);
  endfunction

  function automatic logic signed [AW-1:0] extreme_accel();
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'sh0001;
      4: return 16'shFFFF;
      5: return 16'sh0002;
      default: return 16'shFFFE;
    endcase
  endfunction

  task automatic pick_accel(output logic signed [AW-1:0] x, y, z);
    logic signed [AW-1:0] v [3];
    int target;
    int axis;
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (v[i]) v[i] = AW'($urandom_range(0, 2) - 1);
      end
      2, 3, 4: begin
        // land right on either edge of the band around gravity
        target = $urandom_range(0, 1) ? 1256 + int'(thr_cfg) : 1256 - int'(thr_cfg);
        target = target + $urandom_range(0, 4) - 2;
        if (target < 0) target = -target;
        foreach (v[i]) v[i] = AW'($urandom_range(0, 1));
        axis = $urandom_range(0, 2);
        v[axis] = clamp_accel($urandom_range(0, 1) ? target : -target);
      end
      5, 6: begin
        foreach (v[i]) v[i] = AW'($urandom_range(0, 600) - 300);
        axis = $urandom_range(0, 2);
        v[axis] = clamp_accel(1256 + $urandom_range(0, 800) - 400);
      end
      7: begin
        foreach (v[i]) v[i] = extreme_accel();
      end
      default: begin
        foreach (v[i]) v[i] = AW'($urandom);
      end
    endcase
    x = v[0];
    y = v[1];
    z = v[2];
  endtask

  task automatic send_random_word();
    logic signed [AW-1:0] x, y, z;
    int r;
    r = $urandom_range(0, 99);
    pick_accel(x, y, z);
    if (r < 30) tick();
    else if (r < 86) send_word(KIND_SAMPLE, x, y, z, ($urandom_range(0, 9) != 0));
    else if (r < 92) arm();
    else if (r < 95) send_word(KIND_SAMPLE + KIND_ARM, x, y, z, 1'($urandom));
    else repeat ($urandom_range(5, 70)) tick();
  endtask

  task automatic test_defaults_and_extremes();
    send_word(KIND_SAMPLE + KIND_ARM, 16'sh7FFF, 16'sh8000, 16'sh1234, 1'b1);
    sample(30000, 0, 0);          // ignored while idle
    arm();
    arm();                        // ignored while detecting
    send_word(KIND_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    sample(1, -1, 0);             // near zero on all axes
    sample(0, 0, 1256);
    sample(0, 0, 1512);           // on the upper edge, no hit
    sample(0, 0, 1513);
    sample(0, 0, 1000);           // on the lower edge, no hit
    sample(0, 0, 999);
    sample(-32768, -32768, -32768);
    sample(32767, 32767, 32767);  // ignored once detected
    tick();
    send_word(KIND_SAMPLE + KIND_ARM, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    arm();                        // re-arm from detected
    sample(2, 0, 0);
  endtask

  task automatic test_thresholds();
    set_config(0, 2000, 3000, 3);
    arm();
    sample(0, 0, 1256);
    sample(0, 0, 1257);
    sample(0, 0, -1255);
    sample(1, 1, 1256);
    set_config(32767, 2000, 3000, 3);
    arm();
    sample(2, 0, 0);              // lower bound gone when threshold exceeds gravity
    sample(0, 0, 32767);
    sample(32767, 32767, 32767);
    set_config(1256, 2000, 3000, 3);
    arm();
    sample(2, 0, 0);
    sample(0, 0, 2513);
    set_config(1255, 2000, 3000, 3);
    arm();
    sample(2, 0, 0);
  endtask

  task automatic test_window_timeout();
    set_config(256, 2, 3000, 3);
    arm();
    sample(0, 0, 3000);
    tick();
    tick();
    sample(0, 0, 3000);
    tick();                       // window over, hits cleared
    sample(0, 0, 3000);
    set_config(256, 0, 3000, 3);
    arm();
    sample(0, 0, 3000);
    tick();
  endtask

  task automatic test_cooldown();
    set_config(256, 100, 0, 0);
    arm();
    tick();
    sample(0, 0, 2000);           // enters detected and leaves at once
    set_config(256, 100, 0, 1);
    arm();
    sample(0, 0, 2000);
    tick();
    set_config(256, 100, 3, 2);
    arm();
    sample(0, 0, 2000);
    sample(0, 0, 2000);
    repeat (4) tick();
  endtask

  task automatic test_long_window();
    set_config(256, 65535, 65535, 3);
    arm();
    steady = 1'b1;
    repeat (100) tick();
    steady = 1'b0;
    sample(0, 0, 3000);
    sample(0, 0, 3000);
    sample(0, 0, 3000);
    repeat (3) tick();            // stays detected under the longest cooldown
    set_config(256, 65535, 65534, 3);
    tick();
  endtask

  task automatic test_hit_saturation();
    set_config(256, 65535, 65535, 255);
    arm();
    repeat (256) sample(0, 0, -3000);
  endtask

  task automatic test_backpressure();
    set_config(300, 40, 60, 4);
    @(negedge clk);
    hold_left = 300;
    steady = 1'b1;
    repeat (80) send_random_word();
    steady = 1'b0;
  endtask

  task automatic test_random_mix(input int phases, input int words_per_phase);
    int thr, win, cool, need, start;
    repeat (phases) begin
      case ($urandom_range(0, 5))
        0: thr = 0;
        1: thr = 32767;
        2: thr = 1256;
        3: thr = $urandom_range(0, 32767);
        default: thr = $urandom_range(0, 1500);
      endcase
      case ($urandom_range(0, 5))
        0: win = 0;
        1: win = 65535;
        2: win = $urandom_range(0, 65535);
        default: win = $urandom_range(1, 60);
      endcase
      case ($urandom_range(0, 5))
        0: cool = 0;
        1: cool = 65535;
        2: cool = $urandom_range(0, 65535);
        default: cool = $urandom_range(0, 80);
      endcase
      case ($urandom_range(0, 5))
        0: need = 0;
        1: need = 255;
        2: need = $urandom_range(0, 255);
        default: need = $urandom_range(1, 6);
      endcase
      set_config(thr, win, cool, need);
      start = words_sent;
      while (words_sent - start < words_per_phase) begin
        arm();
        repeat ($urandom_range(4, 40)) send_random_word();
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_TICK;
    in_if.accel_x      = '0;
    in_if.accel_y      = '0;
    in_if.accel_z      = '0;
    in_if.sample_valid = 1'b0;
    thr_cfg            = THRESHOLD_RST;
    window_cfg         = WINDOW_RST;
    cooldown_cfg       = COOLDOWN_RST;
    need_cfg           = HITS_REQ_RST;
    det_mode           = MODE_IDLE;
    hit_tally          = '0;
    elapsed            = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_defaults_and_extremes();
    test_thresholds();
    test_window_timeout();
    test_cooldown();
    test_long_window();
    test_hit_saturation();
    test_backpressure();
    test_random_mix(5, 220);

    wait_results_done();
    $display("Run covered %0d words under %0d register settings: %0d results checked,",
             words_sent, settings_used, results_seen);
    $display("%0d shots flagged, %0d mismatches", shots_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: shot_vibration_detector_core.f
+incdir+hdl
hdl/svd_pkg.sv
hdl/svd_channels.sv
hdl/shot_vibration_detector_core.sv
tb/sv/testbench.sv
